>>> src/dkpc_pkg.sv
// ----------------------------------------------------------------------------
// dkpc_pkg
// Shared types and constants of the doorbell key press classifier.
// ----------------------------------------------------------------------------
package dkpc_pkg;

  localparam int unsigned CFG_ADDR_W = 5;

  // Minimum hold time of a short press, in milliseconds.
  localparam logic [31:0] DEBOUNCE_MS = 32'd50;

  localparam logic [7:0]  HOLD_UNSET    = 8'hFF;
  localparam logic [7:0]  HOLD_DEFAULT  = 8'd10;
  localparam logic [3:0]  SUPP_UNSET    = 4'hF;
  localparam logic [3:0]  SUPP_DEFAULT  = 4'd3;
  localparam logic [14:0] MS_PER_TENTH  = 15'd100;
  localparam logic [13:0] MS_PER_SEC    = 14'd1000;

  typedef enum logic [2:0] {
    REG_ENABLED,
    REG_NOT_INVERTED,
    REG_ACTIVE_HIGH,
    REG_LONG_PRESS_TENTHS,
    REG_SUPPRESS_COUNT,
    REG_SUPPRESS_SECONDS,
    REG_REPEAT_LONG,
    REG_CHANNEL_NUMBER
  } reg_idx_t;

  typedef enum logic [1:0] {
    BUZ_NONE,
    BUZ_SUCCESS,
    BUZ_BLOCKED
  } buzz_t;

  typedef struct packed {
    logic       enabled;
    logic       not_inverted;
    logic       active_high;
    logic [7:0] long_press_tenths;
    logic [3:0] suppress_count;
    logic [3:0] suppress_seconds;
    logic       repeat_long;
    logic [7:0] channel_number;
  } dkpc_cfg_t;

  typedef struct packed {
    logic [31:0] clock_ms;
    logic [31:0] press_start_ms;
    logic [31:0] last_press_start_ms;
    logic [31:0] last_long_ms;
    logic [7:0]  press_counter;
    logic [3:0]  suppress_left;
  } dkpc_state_t;

  typedef struct packed {
    logic       event_valid;
    logic       event_long;
    logic [7:0] press_number;
    logic [7:0] event_channel;
    buzz_t      buzzer_request;
    logic       buzzer_force;
  } dkpc_result_t;

endpackage

>>> src/dkpc_step.sv
// ----------------------------------------------------------------------------
// dkpc_step
// Classification of one millisecond tick: next state and result transaction.
// ----------------------------------------------------------------------------
module dkpc_step import dkpc_pkg::*; (
  input  dkpc_cfg_t    cfg,
  input  dkpc_state_t  st,
  input  logic         pin_level,
  input  logic         line_busy,
  output dkpc_state_t  st_nxt,
  output dkpc_result_t res
);

  logic [31:0] clk_inc;
  logic [31:0] now;
  logic [7:0]  hold_tenths;
  logic [3:0]  cnt;
  logic [3:0]  secs;
  logic [14:0] hold_ms;
  logic [13:0] window;
  logic        released;
  logic [31:0] since_press;
  logic [31:0] since_last_press;
  logic [31:0] since_long;
  logic [3:0]  sl;
  logic [7:0]  counter_inc;

  assign clk_inc     = st.clock_ms + 32'd1;
  // Time zero is reserved as the "not pressed" mark, so it reads as one.
  assign now         = (clk_inc == 32'd0) ? 32'd1 : clk_inc;
  assign hold_tenths = (cfg.long_press_tenths == HOLD_UNSET) ? HOLD_DEFAULT
                                                             : cfg.long_press_tenths;
  assign cnt         = (cfg.suppress_count == SUPP_UNSET) ? SUPP_DEFAULT
                                                          : cfg.suppress_count;
  assign secs        = (cfg.suppress_seconds == SUPP_UNSET) ? SUPP_DEFAULT
                                                            : cfg.suppress_seconds;
  assign hold_ms     = 15'(hold_tenths) * MS_PER_TENTH;
  assign window      = 14'(secs) * MS_PER_SEC;
  assign released    = cfg.active_high ^ pin_level ^ ~cfg.not_inverted;

  assign since_press      = now - st.press_start_ms;
  assign since_last_press = now - st.last_press_start_ms;
  assign since_long       = now - st.last_long_ms;
  assign counter_inc      = st.press_counter + 8'd1;

  // The suppression window expires only while no long event is outstanding.
  assign sl = ((st.suppress_left != 4'd0) && (st.last_long_ms == 32'd0) &&
               (since_last_press >= 32'(window))) ? 4'd0 : st.suppress_left;

  always_comb begin
    st_nxt          = st;
    res             = '0;
    st_nxt.clock_ms = clk_inc;
    if (cfg.enabled) begin
      st_nxt.suppress_left = sl;
      if (released) begin
        if (st.press_start_ms != 32'd0) begin
          if ((since_press >= DEBOUNCE_MS) && (st.last_long_ms == 32'd0)) begin
            if (sl == 4'd0) begin
              st_nxt.press_counter = counter_inc;
              res.event_valid      = 1'b1;
              res.press_number     = counter_inc;
              res.event_channel    = cfg.channel_number;
              if (!line_busy) begin
                st_nxt.suppress_left = cnt;
                res.buzzer_request   = BUZ_SUCCESS;
                res.buzzer_force     = 1'b1;
              end
            end else begin
              st_nxt.suppress_left = sl - 4'd1;
              res.buzzer_request   = BUZ_BLOCKED;
            end
          end
          st_nxt.press_start_ms = 32'd0;
        end
      end else if (st.press_start_ms != 32'd0) begin
        if (st.last_long_ms != 32'd0) begin
          // A long repeat counts as sent even on a busy bus.
          if ((since_long >= 32'(window)) && cfg.repeat_long) begin
            res.event_valid      = 1'b1;
            res.event_long       = 1'b1;
            res.press_number     = st.press_counter;
            res.event_channel    = cfg.channel_number;
            st_nxt.last_long_ms  = now;
            st_nxt.suppress_left = cnt;
            res.buzzer_request   = BUZ_SUCCESS;
          end
        end else if (since_press >= 32'(hold_ms)) begin
          if (sl == 4'd0) begin
            st_nxt.press_counter = counter_inc;
            res.event_valid      = 1'b1;
            res.event_long       = 1'b1;
            res.press_number     = counter_inc;
            res.event_channel    = cfg.channel_number;
            if (!line_busy) begin
              st_nxt.last_long_ms  = now;
              st_nxt.suppress_left = cnt;
              res.buzzer_request   = BUZ_SUCCESS;
            end
          end
        end
      end else begin
        st_nxt.press_start_ms      = now;
        st_nxt.last_press_start_ms = now;
        st_nxt.last_long_ms        = 32'd0;
      end
    end
  end

endmodule

>>> src/doorbell_key_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// doorbell_key_press_classifier_unit
// Classifies debounced key presses into short, long and repeated long events.
// ----------------------------------------------------------------------------
// The result of an accepted tick is loaded into the output register in the next cycle.
// Throughput: one tick per cycle; the tick is classified in a single pass of
// compare logic against the state registers. A new tick is taken in the same
// cycle the held result leaves, and a result held by the receiver stalls input.
// Reset: synchronous, active low; key state and output valid are cleared and
// registers take their documented defaults; the result payload is not reset.
module doorbell_key_press_classifier_unit import dkpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_pin_level,
  input  logic                  in_line_busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_event_valid,
  output logic                  out_event_long,
  output logic [7:0]            out_press_number,
  output logic [7:0]            out_event_channel,
  output logic [1:0]            out_buzzer_request,
  output logic                  out_buzzer_force,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  dkpc_cfg_t    cfg_r;
  dkpc_state_t  st_r;
  dkpc_state_t  st_nxt;
  dkpc_result_t res_nxt;
  dkpc_result_t res_r;
  logic         out_valid_r;
  logic         in_accept;
  logic         cfg_write;
  reg_idx_t     reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled           <= 1'b1;
      cfg_r.not_inverted      <= 1'b1;
      cfg_r.active_high       <= 1'b0;
      cfg_r.long_press_tenths <= HOLD_DEFAULT;
      cfg_r.suppress_count    <= SUPP_DEFAULT;
      cfg_r.suppress_seconds  <= SUPP_DEFAULT;
      cfg_r.repeat_long       <= 1'b0;
      cfg_r.channel_number    <= 8'd0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ENABLED:           cfg_r.enabled           <= pwdata[0];
        REG_NOT_INVERTED:      cfg_r.not_inverted      <= pwdata[0];
        REG_ACTIVE_HIGH:       cfg_r.active_high       <= pwdata[0];
        REG_LONG_PRESS_TENTHS: cfg_r.long_press_tenths <= pwdata[7:0];
        REG_SUPPRESS_COUNT:    cfg_r.suppress_count    <= pwdata[3:0];
        REG_SUPPRESS_SECONDS:  cfg_r.suppress_seconds  <= pwdata[3:0];
        REG_REPEAT_LONG:       cfg_r.repeat_long       <= pwdata[0];
        REG_CHANNEL_NUMBER:    cfg_r.channel_number    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLED:           prdata = 32'(cfg_r.enabled);
      REG_NOT_INVERTED:      prdata = 32'(cfg_r.not_inverted);
      REG_ACTIVE_HIGH:       prdata = 32'(cfg_r.active_high);
      REG_LONG_PRESS_TENTHS: prdata = 32'(cfg_r.long_press_tenths);
      REG_SUPPRESS_COUNT:    prdata = 32'(cfg_r.suppress_count);
      REG_SUPPRESS_SECONDS:  prdata = 32'(cfg_r.suppress_seconds);
      REG_REPEAT_LONG:       prdata = 32'(cfg_r.repeat_long);
      REG_CHANNEL_NUMBER:    prdata = 32'(cfg_r.channel_number);
      default:               prdata = 32'd0;
    endcase
  end

  dkpc_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .pin_level (in_pin_level),
    .line_busy (in_line_busy),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; only loaded when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_valid    = res_r.event_valid;
  assign out_event_long     = res_r.event_long;
  assign out_press_number   = res_r.press_number;
  assign out_event_channel  = res_r.event_channel;
  assign out_buzzer_request = 2'(res_r.buzzer_request);
  assign out_buzzer_force   = res_r.buzzer_force;

  a_clock_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> st_r.clock_ms == $past(st_r.clock_ms) + 32'd1)
    else $error("millisecond clock did not advance by one per tick");

  a_counter_with_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (st_r.press_counter == $past(st_r.press_counter)) ||
                  (out_event_valid && (out_press_number == st_r.press_counter)))
    else $error("press counter moved without a matching event");

  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_event_valid) |->
      (!out_event_long && (out_press_number == 8'd0) && (out_event_channel == 8'd0)))
    else $error("event fields set without an event");

  a_force_needs_tune: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_buzzer_force) |-> (res_r.buzzer_request == BUZ_SUCCESS))
    else $error("buzzer force without a success tune");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !cfg_r.enabled) |=>
      ((st_r.press_start_ms == $past(st_r.press_start_ms)) &&
       !out_event_valid && (res_r.buzzer_request == BUZ_NONE)))
    else $error("disabled block changed key state or raised an event");

endmodule

>>> tb/dkpc_event_checker.sv
// ----------------------------------------------------------------------------
// dkpc_event_checker
// Watches the tick, result and register ports of the key press classifier,
// predicts every result from its own copy of the state and compares fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dkpc_event_checker import dkpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_pin_level,
  input  logic                  in_line_busy,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_event_valid,
  input  logic                  out_event_long,
  input  logic [7:0]            out_press_number,
  input  logic [7:0]            out_event_channel,
  input  logic [1:0]            out_buzzer_request,
  input  logic                  out_buzzer_force,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int                    pending,
  output int                    mismatches,
  output int                    events_checked
);

  dkpc_cfg_t    cfg;
  logic [31:0]  ms_clock;
  logic [31:0]  press_at;
  logic [31:0]  last_press_at;
  logic [31:0]  long_at;
  logic [7:0]   press_count;
  logic [3:0]   blocked_left;
  dkpc_result_t expected_events[$];
  int           err_count;
  int           event_count;

  assign mismatches     = err_count;
  assign events_checked = event_count;

  initial begin
    err_count   = 0;
    event_count = 0;
  end

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (err_count < 40) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
    end
    err_count++;
  endtask

  // Advances the millisecond clock by one tick and classifies the key level.
  function automatic dkpc_result_t classify_tick(input logic pin, input logic busy);
    dkpc_result_t r;
    logic [31:0]  now;
    logic [31:0]  hold_ms;
    logic [31:0]  window_ms;
    logic [7:0]   tenths;
    logic [3:0]   block_cnt;
    logic [3:0]   secs;
    logic         released;
    r = '0;
    ms_clock = ms_clock + 32'd1;
    if (cfg.enabled) begin
      now       = (ms_clock == 32'd0) ? 32'd1 : ms_clock;
      tenths    = (cfg.long_press_tenths == HOLD_UNSET) ? HOLD_DEFAULT
                                                        : cfg.long_press_tenths;
      block_cnt = (cfg.suppress_count == SUPP_UNSET) ? SUPP_DEFAULT : cfg.suppress_count;
      secs      = (cfg.suppress_seconds == SUPP_UNSET) ? SUPP_DEFAULT
                                                       : cfg.suppress_seconds;
      hold_ms   = 32'(tenths) * 32'(MS_PER_TENTH);
      window_ms = 32'(secs) * 32'(MS_PER_SEC);
      released  = cfg.active_high ^ pin ^ ~cfg.not_inverted;

      // Suppression lapses once the window since the last press start is over,
      // unless a long event is still standing.
      if (blocked_left != 4'd0 && long_at == 32'd0 &&
          (now - last_press_at) >= window_ms) begin
        blocked_left = 4'd0;
      end

      if (released) begin
        if (press_at != 32'd0) begin
          if ((now - press_at) >= DEBOUNCE_MS && long_at == 32'd0) begin
            if (blocked_left == 4'd0) begin
              press_count     = press_count + 8'd1;
              r.event_valid   = 1'b1;
              r.press_number  = press_count;
              r.event_channel = cfg.channel_number;
              if (!busy) begin
                blocked_left     = block_cnt;
                r.buzzer_request = BUZ_SUCCESS;
                r.buzzer_force   = 1'b1;
              end
            end else begin
              blocked_left     = blocked_left - 4'd1;
              r.buzzer_request = BUZ_BLOCKED;
            end
          end
          press_at = 32'd0;
        end
      end else if (press_at != 32'd0) begin
        if (long_at != 32'd0) begin
          // A repeat counts as sent even when the bus is busy.
          if ((now - long_at) >= window_ms && cfg.repeat_long) begin
            r.event_valid    = 1'b1;
            r.event_long     = 1'b1;
            r.press_number   = press_count;
            r.event_channel  = cfg.channel_number;
            r.buzzer_request = BUZ_SUCCESS;
            long_at          = now;
            blocked_left     = block_cnt;
          end
        end else if ((now - press_at) >= hold_ms && blocked_left == 4'd0) begin
          press_count     = press_count + 8'd1;
          r.event_valid   = 1'b1;
          r.event_long    = 1'b1;
          r.press_number  = press_count;
          r.event_channel = cfg.channel_number;
          if (!busy) begin
            long_at          = now;
            blocked_left     = block_cnt;
            r.buzzer_request = BUZ_SUCCESS;
          end
        end
      end else begin
        press_at      = now;
        last_press_at = now;
        long_at       = 32'd0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch_ports
    dkpc_result_t want;
    if (!rst_n) begin
      cfg.enabled           = 1'b1;
      cfg.not_inverted      = 1'b1;
      cfg.active_high       = 1'b0;
      cfg.long_press_tenths = 8'd10;
      cfg.suppress_count    = 4'd3;
      cfg.suppress_seconds  = 4'd3;
      cfg.repeat_long       = 1'b0;
      cfg.channel_number    = 8'd0;
      ms_clock              = '0;
      press_at              = '0;
      last_press_at         = '0;
      long_at               = '0;
      press_count           = '0;
      blocked_left          = '0;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_ENABLED:           cfg.enabled           = pwdata[0];
          REG_NOT_INVERTED:      cfg.not_inverted      = pwdata[0];
          REG_ACTIVE_HIGH:       cfg.active_high       = pwdata[0];
          REG_LONG_PRESS_TENTHS: cfg.long_press_tenths = pwdata[7:0];
          REG_SUPPRESS_COUNT:    cfg.suppress_count    = pwdata[3:0];
          REG_SUPPRESS_SECONDS:  cfg.suppress_seconds  = pwdata[3:0];
          REG_REPEAT_LONG:       cfg.repeat_long       = pwdata[0];
          REG_CHANNEL_NUMBER:    cfg.channel_number    = pwdata[7:0];
          default: ;
        endcase
      end

      // Results leave before this edge's tick is classified, so a result
      // accepted here always belongs to an earlier tick.
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_event_valid), 32'd0);
        end else begin
          want = expected_events.pop_front();
          if (want.event_valid) event_count++;
          if (out_event_valid !== want.event_valid)
            report_mismatch("event_valid", 32'(out_event_valid),
                            32'(want.event_valid));
          if (out_event_long !== want.event_long)
            report_mismatch("event_long", 32'(out_event_long), 32'(want.event_long));
          if (out_press_number !== want.press_number)
            report_mismatch("press_number", 32'(out_press_number),
                            32'(want.press_number));
          if (out_event_channel !== want.event_channel)
            report_mismatch("event_channel", 32'(out_event_channel),
                            32'(want.event_channel));
          if (out_buzzer_request !== want.buzzer_request)
            report_mismatch("buzzer_request", 32'(out_buzzer_request),
                            32'(want.buzzer_request));
          if (out_buzzer_force !== want.buzzer_force)
            report_mismatch("buzzer_force", 32'(out_buzzer_force),
                            32'(want.buzzer_force));
        end
      end

      if (in_valid && in_ready) begin
        expected_events.push_back(classify_tick(in_pin_level, in_line_busy));
      end
    end
    pending <= expected_events.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives millisecond ticks shaped as key presses of many lengths through a
// series of register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import dkpc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT     = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_pin_level;
  logic                  in_line_busy;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_event_valid;
  logic                  out_event_long;
  logic [7:0]            out_press_number;
  logic [7:0]            out_event_channel;
  logic [1:0]            out_buzzer_request;
  logic                  out_buzzer_force;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int   pending;
  int   fail_count;
  int   events_checked;
  int   ticks_sent;
  int   settings_run;
  int   stall_cycles;
  logic no_idle;
  logic hold_off_req;

  // Copies of the settings that shape the stimulus.
  logic pol_active_high;
  logic pol_not_inverted;
  int   hold_ms;
  int   window_ms;
  logic repeat_on;

  doorbell_key_press_classifier_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pin_level       (in_pin_level),
    .in_line_busy       (in_line_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_valid    (out_event_valid),
    .out_event_long     (out_event_long),
    .out_press_number   (out_press_number),
    .out_event_channel  (out_event_channel),
    .out_buzzer_request (out_buzzer_request),
    .out_buzzer_force   (out_buzzer_force),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  dkpc_event_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pin_level       (in_pin_level),
    .in_line_busy       (in_line_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_valid    (out_event_valid),
    .out_event_long     (out_event_long),
    .out_press_number   (out_press_number),
    .out_event_channel  (out_event_channel),
    .out_buzzer_request (out_buzzer_request),
    .out_buzzer_force   (out_buzzer_force),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pending            (pending),
    .mismatches         (fail_count),
    .events_checked     (events_checked)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: random stalls, long runs of ready, and one long hold-off
  // on request so that the block fills up and pushes back on its input.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Ends the run when nothing has moved on any port for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("doorbell_key_press_classifier_unit: mismatch");
    $finish;
  end

  // One tick transaction; pressed is the logical key state, mapped onto the
  // pin through the current polarity settings.
  task automatic send_tick(input logic pressed, input int busy_pct);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= ~pressed ^ pol_active_high ^ ~pol_not_inverted;
    in_line_busy <= ($urandom_range(0, 99) < busy_pct);
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic hold_key(input int count, input logic pressed, input int busy_pct);
    repeat (count) send_tick(pressed, busy_pct);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Lets every expected result drain before the registers change.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_settings(input logic en, input logic not_inv, input logic act_high,
                                input logic [7:0] tenths, input logic [3:0] blocks,
                                input logic [3:0] secs, input logic rep,
                                input logic [7:0] chan);
    drain_results();
    cfg_write(REG_ENABLED,           {31'd0, en});
    cfg_write(REG_NOT_INVERTED,      {31'd0, not_inv});
    cfg_write(REG_ACTIVE_HIGH,       {31'd0, act_high});
    cfg_write(REG_LONG_PRESS_TENTHS, {24'd0, tenths});
    cfg_write(REG_SUPPRESS_COUNT,    {28'd0, blocks});
    cfg_write(REG_SUPPRESS_SECONDS,  {28'd0, secs});
    cfg_write(REG_REPEAT_LONG,       {31'd0, rep});
    cfg_write(REG_CHANNEL_NUMBER,    {24'd0, chan});
    pol_active_high  = act_high;
    pol_not_inverted = not_inv;
    hold_ms          = (tenths == HOLD_UNSET) ? 1000 : int'(tenths) * 100;
    window_ms        = (secs == SUPP_UNSET) ? 3000 : int'(secs) * 1000;
    repeat_on        = rep;
    settings_run++;
  endtask

  // One random key gesture: bounce, short press, long press with optional
  // repeats, pin noise, or a rest between presses.
  task automatic random_gesture();
    int kind;
    int down;
    kind = $urandom_range(0, 11);
    if (kind == 10) begin
      repeat ($urandom_range(5, 30)) send_tick(1'($urandom_range(0, 1)), 25);
    end else if (kind == 11) begin
      hold_key($urandom_range(100, 400), 1'b0, 25);
    end else begin
      if (kind < 2) begin
        down = $urandom_range(1, 49);
      end else if (kind < 6 || hold_ms > 2000) begin
        down = $urandom_range(50, 150);
      end else begin
        down = hold_ms + $urandom_range(1, 60);
        if (repeat_on && window_ms <= 1000 && $urandom_range(0, 3) == 0) begin
          down = down + window_ms + $urandom_range(0, 30);
        end
      end
      hold_key(down, 1'b1, 25);
      hold_key($urandom_range(1, 60), 1'b0, 25);
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) random_gesture();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_pin_level     = 1'b1;
    in_line_busy     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    ticks_sent       = 0;
    settings_run     = 0;
    no_idle          = 1'b0;
    hold_off_req     = 1'b0;
    pol_active_high  = 1'b0;
    pol_not_inverted = 1'b1;
    hold_ms          = 1000;
    window_ms        = 3000;
    repeat_on        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bounce, busy short press, short press, blocked press, then a
    // long press whose first send is busy.
    apply_settings(1'b1, 1'b1, 1'b0, 8'd1, 4'd1, 4'd1, 1'b1, 8'hFF);
    hold_key(49, 1'b1, 0);
    hold_key(5, 1'b0, 0);
    hold_key(50, 1'b1, 0);
    hold_key(1, 1'b0, 100);
    hold_key(5, 1'b0, 0);
    hold_key(50, 1'b1, 0);
    hold_key(1, 1'b0, 0);
    hold_key(60, 1'b1, 0);
    hold_key(1, 1'b0, 0);
    hold_key(5, 1'b0, 0);
    hold_key(101, 1'b1, 100);
    hold_key(2, 1'b1, 0);
    hold_key(21, 1'b0, 0);

    // Directed: a zero window gives a repeat on every held tick, busy ones
    // included, and lets suppression lapse at once after the next press.
    apply_settings(1'b1, 1'b1, 1'b0, 8'd1, 4'd2, 4'd0, 1'b1, 8'h11);
    hold_key(101, 1'b1, 0);
    hold_key(5, 1'b1, 100);
    hold_key(5, 1'b0, 0);
    hold_key(60, 1'b1, 0);
    hold_key(5, 1'b0, 0);

    // Random gestures across register settings, extremes included.
    apply_settings(1'b1, 1'b1, 1'b0, 8'd0, 4'd0, 4'd0, 1'b1, 8'hA5);
    run_random(80);
    apply_settings(1'b1, 1'b0, 1'b0, 8'd1, 4'd2, 4'd1, 1'b0, 8'h00);
    run_random(80);
    apply_settings(1'b1, 1'b1, 1'b1, 8'd2, 4'd14, 4'd0, 1'b1, 8'hFF);
    hold_off_req = 1'b1;
    run_random(120);
    apply_settings(1'b1, 1'b0, 1'b1, 8'hFF, 4'hF, 4'hF, 1'b0, 8'h3C);
    run_random(100);
    apply_settings(1'b0, 1'b1, 1'b0, 8'd254, 4'd1, 4'd14, 1'b1, 8'h5A);
    run_random(40);
    apply_settings(1'b1, 1'b1, 1'b0, 8'd254, 4'd1, 4'd14, 1'b1, 8'h5A);
    run_random(60);
    apply_settings(1'b1, 1'b1, 1'b0, 8'd1, 4'd3, 4'd0, 1'b1, 8'($urandom_range(0, 255)));
    no_idle = 1'b1;
    run_random(120);

    drain_results();
    repeat (5) @(posedge clk);
    $display("Sent %0d key ticks under %0d register settings, including a long result stall.",
             ticks_sent, settings_run);
    $display("Checked %0d key events along with every idle tick.", events_checked);
    if (fail_count == 0) begin
      $display("doorbell_key_press_classifier_unit: match");
    end else begin
      $display("doorbell_key_press_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
src/dkpc_pkg.sv
src/dkpc_step.sv
src/doorbell_key_press_classifier_unit.sv
tb/dkpc_event_checker.sv
tb/tb_top.sv
